### design/qlfo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qlfo_pkg
// Shared types and constants of the quadrature LFO envelope.
// ----------------------------------------------------------------------------
package qlfo_pkg;

  // Oscillator state and configuration registers, signed fixed point
  localparam int STATE_BITS = 24;
  localparam int FRAC_BITS  = 22;
  localparam int CFG_BITS   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_CH     = 8;
  localparam int NUM_GAIN   = 4;

  typedef logic signed [STATE_BITS-1:0] state_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_ROT_COS = 2'd0;
  localparam cfg_idx_t REG_ROT_SIN = 2'd1;
  localparam cfg_idx_t REG_START_X = 2'd2;
  localparam cfg_idx_t REG_START_Y = 2'd3;

  // Request actions
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_RELOAD = 1'b1;

  localparam state_t ONE_Q   = state_t'(1) <<< FRAC_BITS;
  localparam state_t STATE_0 = '0;

endpackage : qlfo_pkg
`default_nettype wire

### design/qlfo_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qlfo_rotate
// Rotates (x, y) by [c -s; s c], rounds half up and saturates to the state width.
// ----------------------------------------------------------------------------
module qlfo_rotate
  import qlfo_pkg::*;
(
  input  wire state_t x,
  input  wire state_t y,
  input  wire state_t rot_cos,
  input  wire state_t rot_sin,
  output state_t next_x,
  output state_t next_y
);

  localparam int PROD_W = 2 * STATE_BITS;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] MAX_SV = SUM_W'({1'b0, {(STATE_BITS-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] MIN_SV = -MAX_SV - SUM_W'(1);

  function automatic state_t round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] sh;
    sh = (v + HALF) >>> FRAC_BITS;
    if (sh > MAX_SV) begin
      return MAX_SV[STATE_BITS-1:0];
    end else if (sh < MIN_SV) begin
      return MIN_SV[STATE_BITS-1:0];
    end else begin
      return sh[STATE_BITS-1:0];
    end
  endfunction

  logic signed [PROD_W-1:0] p_cx;
  logic signed [PROD_W-1:0] p_sy;
  logic signed [PROD_W-1:0] p_sx;
  logic signed [PROD_W-1:0] p_cy;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;

  assign p_cx = rot_cos * x;
  assign p_sy = rot_sin * y;
  assign p_sx = rot_sin * x;
  assign p_cy = rot_cos * y;

  // full-precision row sums before the single rounding step
  assign sum_x = SUM_W'(p_cx) - SUM_W'(p_sy);
  assign sum_y = SUM_W'(p_sx) + SUM_W'(p_cy);

  assign next_x = round_sat(sum_x);
  assign next_y = round_sat(sum_y);

endmodule : qlfo_rotate
`default_nettype wire

### design/qlfo_gain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qlfo_gain
// Scales one audio sample by an oscillator gain, rounds half up, saturates.
// ----------------------------------------------------------------------------
module qlfo_gain
  import qlfo_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire state_t                        gain,
  output logic signed [SAMPLE_BITS-1:0]      scaled
);

  localparam int PROD_W = SAMPLE_BITS + STATE_BITS;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] MAX_SV = SUM_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] MIN_SV = -MAX_SV - SUM_W'(1);

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sh;

  assign prod = sample * gain;
  assign sh   = (SUM_W'(prod) + HALF) >>> FRAC_BITS;

  always_comb begin
    if (sh > MAX_SV) begin
      scaled = MAX_SV[SAMPLE_BITS-1:0];
    end else if (sh < MIN_SV) begin
      scaled = MIN_SV[SAMPLE_BITS-1:0];
    end else begin
      scaled = sh[SAMPLE_BITS-1:0];
    end
  end

endmodule : qlfo_gain
`default_nettype wire

### design/quadrature_lfo_envelope.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_lfo_envelope
// Quadrature sine/cosine LFO driving a four-way stereo volume envelope.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Contents
// in_      request    in_valid/in_stall   action, four stereo sample pairs
// out_     result     out_valid/out_stall sine, cosine, eight gained samples, flags
// cfg_     write      cfg_we              rot_cos, rot_sin, start_x, start_y
//
// One request per cycle sustained while out_stall is low; a request enters the
// input register, then its result the result register on the outputs. The
// rotation feedback through the four 24x24 multipliers is combinational
// between the oscillator registers. Reset is synchronous and loads the register
// defaults and the start vector. A stalled result holds the input register;
// in_stall rises only when both registers are full and the result is stalled.
// ----------------------------------------------------------------------------
module quadrature_lfo_envelope
  import qlfo_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst_n,

  input  wire  logic                          cfg_we,
  input  wire  cfg_idx_t                      cfg_index,
  input  wire  logic [CFG_BITS-1:0]           cfg_data,

  input  wire  logic                          in_valid,
  output       logic                          in_stall,
  input  wire  logic                          in_action,
  input  wire  logic signed [SAMPLE_BITS-1:0] in_ch0_left,
  input  wire  logic signed [SAMPLE_BITS-1:0] in_ch0_right,
  input  wire  logic signed [SAMPLE_BITS-1:0] in_ch1_left,
  input  wire  logic signed [SAMPLE_BITS-1:0] in_ch1_right,
  input  wire  logic signed [SAMPLE_BITS-1:0] in_ch2_left,
  input  wire  logic signed [SAMPLE_BITS-1:0] in_ch2_right,
  input  wire  logic signed [SAMPLE_BITS-1:0] in_ch3_left,
  input  wire  logic signed [SAMPLE_BITS-1:0] in_ch3_right,

  output       logic                          out_valid,
  input  wire  logic                          out_stall,
  output       state_t                        out_sine_out,
  output       state_t                        out_cosine_out,
  output       logic signed [SAMPLE_BITS-1:0] out_gained0_left,
  output       logic signed [SAMPLE_BITS-1:0] out_gained0_right,
  output       logic signed [SAMPLE_BITS-1:0] out_gained1_left,
  output       logic signed [SAMPLE_BITS-1:0] out_gained1_right,
  output       logic signed [SAMPLE_BITS-1:0] out_gained2_left,
  output       logic signed [SAMPLE_BITS-1:0] out_gained2_right,
  output       logic signed [SAMPLE_BITS-1:0] out_gained3_left,
  output       logic signed [SAMPLE_BITS-1:0] out_gained3_right,
  output       logic [NUM_GAIN-1:0]           out_gain_flags
);

  function automatic logic [NUM_GAIN-1:0] flags_of(input state_t x, input state_t y);
    return {y[STATE_BITS-1], !y[STATE_BITS-1] && (y != STATE_0),
            x[STATE_BITS-1], !x[STATE_BITS-1] && (x != STATE_0)};
  endfunction

  // Configuration registers
  state_t rot_cos_r;
  state_t rot_sin_r;
  state_t start_x_r;
  state_t start_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cos_r <= ONE_Q;
      rot_sin_r <= STATE_0;
      start_x_r <= STATE_0;
      start_y_r <= -ONE_Q;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROT_COS: rot_cos_r <= cfg_data;
        REG_ROT_SIN: rot_sin_r <= cfg_data;
        REG_START_X: start_x_r <= cfg_data;
        REG_START_Y: start_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                          in_valid_r;
  logic                          action_r;
  logic signed [SAMPLE_BITS-1:0] smp_r [NUM_CH];
  logic                          out_valid_r;
  logic                          advance;
  logic                          load_in;
  logic                          fire;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign load_in  = in_valid && !in_stall;
  assign fire     = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (load_in) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      action_r <= in_action;
      smp_r[0] <= in_ch0_left;
      smp_r[1] <= in_ch0_right;
      smp_r[2] <= in_ch1_left;
      smp_r[3] <= in_ch1_right;
      smp_r[4] <= in_ch2_left;
      smp_r[5] <= in_ch2_right;
      smp_r[6] <= in_ch3_left;
      smp_r[7] <= in_ch3_right;
    end
  end

  // Oscillator state and datapath
  state_t osc_x_r;
  state_t osc_y_r;
  state_t next_x;
  state_t next_y;
  state_t gain     [NUM_GAIN];
  logic signed [SAMPLE_BITS-1:0] scaled [NUM_CH];

  assign gain[0] = osc_x_r[STATE_BITS-1] ? STATE_0 : osc_x_r;
  assign gain[1] = osc_x_r[STATE_BITS-1] ? osc_x_r : STATE_0;
  assign gain[2] = osc_y_r[STATE_BITS-1] ? STATE_0 : osc_y_r;
  assign gain[3] = osc_y_r[STATE_BITS-1] ? osc_y_r : STATE_0;

  qlfo_rotate u_rotate (
    .x       (osc_x_r),
    .y       (osc_y_r),
    .rot_cos (rot_cos_r),
    .rot_sin (rot_sin_r),
    .next_x  (next_x),
    .next_y  (next_y)
  );

  for (genvar k = 0; k < NUM_CH; k++) begin : g_gain
    qlfo_gain #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_gain (
      .sample (smp_r[k]),
      .gain   (gain[k/2]),
      .scaled (scaled[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_x_r <= STATE_0;
      osc_y_r <= -ONE_Q;
    end else if (fire) begin
      if (action_r == ACT_RELOAD) begin
        osc_x_r <= start_x_r;
        osc_y_r <= start_y_r;
      end else begin
        osc_x_r <= next_x;
        osc_y_r <= next_y;
      end
    end
  end

  // Result register
  state_t                        sine_r;
  state_t                        cosine_r;
  logic signed [SAMPLE_BITS-1:0] gained_r [NUM_CH];
  logic [NUM_GAIN-1:0]           flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (action_r == ACT_RELOAD) begin
        sine_r   <= start_y_r;
        cosine_r <= start_x_r;
        flags_r  <= flags_of(start_x_r, start_y_r);
        for (int i = 0; i < NUM_CH; i++) begin
          gained_r[i] <= '0;
        end
      end else begin
        sine_r   <= osc_y_r;
        cosine_r <= osc_x_r;
        flags_r  <= flags_of(next_x, next_y);
        for (int i = 0; i < NUM_CH; i++) begin
          gained_r[i] <= scaled[i];
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sine_out      = sine_r;
  assign out_cosine_out    = cosine_r;
  assign out_gained0_left  = gained_r[0];
  assign out_gained0_right = gained_r[1];
  assign out_gained1_left  = gained_r[2];
  assign out_gained1_right = gained_r[3];
  assign out_gained2_left  = gained_r[4];
  assign out_gained2_right = gained_r[5];
  assign out_gained3_left  = gained_r[6];
  assign out_gained3_right = gained_r[7];
  assign out_gain_flags    = flags_r;

endmodule : quadrature_lfo_envelope
`default_nettype wire

### bench/tb_quadrature_lfo_envelope.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_lfo_envelope
// Self-checking bench for the quadrature LFO envelope. It computes every
// frame in its own oscillator model, with the same rotation, rounding and
// saturation as the block. Each result is compared field by field with the
// oldest predicted frame. Stimulus runs directed corner cases first, then
// random requests under several idle and stall mixes, then a long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_quadrature_lfo_envelope;
  import qlfo_pkg::*;

  localparam int     SAMPLE_BITS   = 24;
  localparam int     CLK_HALF_NS   = 10;
  localparam int     RESET_CYCLES  = 5;
  localparam int     SETTLE_CYCLES = 6;
  localparam int     DRAIN_LIMIT   = 20000;
  localparam int     TIMEOUT_NS    = 4_000_000;
  localparam int     SHOW_LIMIT    = 10;
  localparam longint Q_MAX         = 64'sd8388607;
  localparam longint Q_MIN         = -64'sd8388608;
  localparam longint Q_ONE         = longint'(ONE_Q);
  localparam real    Q_ONE_R       = 4194304.0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic                              action;
    logic [NUM_CH-1:0][SAMPLE_BITS-1:0] ch;
  } lfo_req_t;

  typedef struct packed {
    state_t                            sine;
    state_t                            cosine;
    logic [NUM_CH-1:0][SAMPLE_BITS-1:0] gained;
    logic [NUM_GAIN-1:0]               flags;
  } lfo_frame_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  cfg_idx_t            cfg_index = REG_ROT_COS;
  logic [CFG_BITS-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_action = ACT_TICK;
  sample_t             in_ch0_left  = '0;
  sample_t             in_ch0_right = '0;
  sample_t             in_ch1_left  = '0;
  sample_t             in_ch1_right = '0;
  sample_t             in_ch2_left  = '0;
  sample_t             in_ch2_right = '0;
  sample_t             in_ch3_left  = '0;
  sample_t             in_ch3_right = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  state_t              out_sine_out;
  state_t              out_cosine_out;
  sample_t             out_gained0_left;
  sample_t             out_gained0_right;
  sample_t             out_gained1_left;
  sample_t             out_gained1_right;
  sample_t             out_gained2_left;
  sample_t             out_gained2_right;
  sample_t             out_gained3_left;
  sample_t             out_gained3_right;
  logic [NUM_GAIN-1:0] out_gain_flags;

  // Oscillator model: configuration and vector
  longint cfg_cos = Q_ONE;
  longint cfg_sin = 0;
  longint load_x  = 0;
  longint load_y  = -Q_ONE;
  longint vec_x   = 0;
  longint vec_y   = -Q_ONE;

  lfo_frame_t frames_due [$];
  lfo_frame_t frame_seen;
  lfo_frame_t frame_want;
  int         fault_count    = 0;
  int         src_idle_pct   = 0;
  int         sink_stall_pct = 0;
  logic       hold_go        = 1'b0;
  logic       hold_ack       = 1'b0;
  int         hold_len       = 0;
  int         hold_count     = 0;

  quadrature_lfo_envelope #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_ch0_left      (in_ch0_left),
    .in_ch0_right     (in_ch0_right),
    .in_ch1_left      (in_ch1_left),
    .in_ch1_right     (in_ch1_right),
    .in_ch2_left      (in_ch2_left),
    .in_ch2_right     (in_ch2_right),
    .in_ch3_left      (in_ch3_left),
    .in_ch3_right     (in_ch3_right),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sine_out     (out_sine_out),
    .out_cosine_out   (out_cosine_out),
    .out_gained0_left (out_gained0_left),
    .out_gained0_right(out_gained0_right),
    .out_gained1_left (out_gained1_left),
    .out_gained1_right(out_gained1_right),
    .out_gained2_left (out_gained2_left),
    .out_gained2_right(out_gained2_right),
    .out_gained3_left (out_gained3_left),
    .out_gained3_right(out_gained3_right),
    .out_gain_flags   (out_gain_flags)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Round to nearest, ties toward plus infinity; >>> floors on longint
  function automatic longint round_shift(input longint v);
    return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint clamp_to(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic [NUM_GAIN-1:0] sign_flags(input longint x, input longint y);
    return {y < 0, y > 0, x < 0, x > 0};
  endfunction

  // Emit the frame for one request and advance the oscillator vector
  function automatic lfo_frame_t envelope_step(input lfo_req_t req);
    lfo_frame_t f;
    longint     x;
    longint     y;
    longint     s;
    longint     gain [NUM_GAIN];
    f = '0;
    x = vec_x;
    y = vec_y;
    if (req.action == ACT_RELOAD) begin
      vec_x    = load_x;
      vec_y    = load_y;
      f.sine   = state_t'(vec_y);
      f.cosine = state_t'(vec_x);
      f.flags  = sign_flags(vec_x, vec_y);
      return f;
    end
    gain[0]  = (x > 0) ? x : 0;
    gain[1]  = (x < 0) ? x : 0;
    gain[2]  = (y > 0) ? y : 0;
    gain[3]  = (y < 0) ? y : 0;
    f.sine   = state_t'(y);
    f.cosine = state_t'(x);
    for (int k = 0; k < NUM_CH; k++) begin
      s           = longint'($signed(req.ch[k]));
      f.gained[k] = sample_t'(clamp_to(round_shift(s * gain[k >> 1]), SAMPLE_BITS));
    end
    vec_x   = clamp_to(round_shift(cfg_cos * x - cfg_sin * y), STATE_BITS);
    vec_y   = clamp_to(round_shift(cfg_sin * x + cfg_cos * y), STATE_BITS);
    f.flags = sign_flags(vec_x, vec_y);
    return f;
  endfunction

  task automatic note_fault(input string what, input longint want, input longint got);
    fault_count++;
    if (fault_count <= SHOW_LIMIT)
      $display("mismatch %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
  endtask

  task automatic compare_field(input string what, input longint want, input longint got);
    if (want != got) note_fault(what, want, got);
  endtask

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_go != hold_ack) begin
      hold_ack   <= hold_go;
      hold_count <= hold_len;
      out_stall  <= 1'b1;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      frame_seen.sine   = out_sine_out;
      frame_seen.cosine = out_cosine_out;
      frame_seen.gained = {out_gained3_right, out_gained3_left, out_gained2_right,
                           out_gained2_left, out_gained1_right, out_gained1_left,
                           out_gained0_right, out_gained0_left};
      frame_seen.flags  = out_gain_flags;
      if (frames_due.size() == 0) begin
        note_fault("unexpected result, sine", 0, longint'(frame_seen.sine));
      end else begin
        frame_want = frames_due.pop_front();
        compare_field("sine_out", frame_want.sine, frame_seen.sine);
        compare_field("cosine_out", frame_want.cosine, frame_seen.cosine);
        for (int k = 0; k < NUM_CH; k++)
          compare_field($sformatf("gained%0d_%s", k >> 1, (k % 2) ? "right" : "left"),
                        $signed(frame_want.gained[k]), $signed(frame_seen.gained[k]));
        compare_field("gain_flags", frame_want.flags, frame_seen.flags);
      end
    end
  end

  task automatic send_request(input lfo_req_t req);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= req.action;
    in_ch0_left  <= req.ch[0];
    in_ch0_right <= req.ch[1];
    in_ch1_left  <= req.ch[2];
    in_ch1_right <= req.ch[3];
    in_ch2_left  <= req.ch[4];
    in_ch2_right <= req.ch[5];
    in_ch3_left  <= req.ch[6];
    in_ch3_right <= req.ch[7];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_due.push_back(envelope_step(req));
  endtask

  // Drop valid, wait for every predicted frame, then let the pipeline settle
  task automatic wait_drained();
    int spins;
    in_valid <= 1'b0;
    spins = 0;
    while (frames_due.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input longint value);
    logic [CFG_BITS-1:0] word;
    longint              v;
    word      = value[CFG_BITS-1:0];
    v         = longint'($signed(word));
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    case (idx)
      REG_ROT_COS: cfg_cos = v;
      REG_ROT_SIN: cfg_sin = v;
      REG_START_X: load_x  = v;
      REG_START_Y: load_y  = v;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setup(input longint c, input longint s, input longint x,
                            input longint y);
    wait_drained();
    write_reg(REG_ROT_COS, c);
    write_reg(REG_ROT_SIN, s);
    write_reg(REG_START_X, x);
    write_reg(REG_START_Y, y);
  endtask

  task automatic program_random_setup();
    real    ang;
    real    amp;
    longint c;
    longint s;
    longint x;
    longint y;
    ang = $urandom_range(62831) / 10000.0;
    if ($urandom_range(9) < 7) begin
      c = longint'($rtoi($cos(ang) * Q_ONE_R));
      s = longint'($rtoi($sin(ang) * Q_ONE_R));
    end else begin
      c = longint'($urandom);
      s = longint'($urandom);
    end
    ang = $urandom_range(62831) / 10000.0;
    amp = $urandom_range(19000) / 10000.0;
    if ($urandom_range(9) < 6) begin
      x = longint'($rtoi(amp * $cos(ang) * Q_ONE_R));
      y = longint'($rtoi(amp * $sin(ang) * Q_ONE_R));
    end else begin
      x = longint'($urandom);
      y = longint'($urandom);
    end
    load_setup(c, s, x, y);
  endtask

  function automatic lfo_req_t make_request(input logic act, input longint left,
                                            input longint right);
    lfo_req_t r;
    r.action = act;
    for (int k = 0; k < NUM_CH; k++)
      r.ch[k] = (k % 2) ? sample_t'(right) : sample_t'(left);
    return r;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0:       return sample_t'(Q_MAX);
      1:       return sample_t'(Q_MIN);
      2:       return sample_t'(int'($urandom_range(8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic lfo_req_t random_request(input int reload_pct);
    lfo_req_t r;
    r.action = ($urandom_range(99) < reload_pct) ? ACT_RELOAD : ACT_TICK;
    for (int k = 0; k < NUM_CH; k++)
      r.ch[k] = random_sample();
    return r;
  endfunction

  // Register defaults hold the vector at (0, -1): only channel 3 gets gain
  task automatic test_reset_defaults();
    send_request(make_request(ACT_TICK, Q_MAX, Q_MAX));
    send_request(make_request(ACT_TICK, Q_MIN, Q_MIN));
    send_request(make_request(ACT_TICK, 0, 0));
    send_request(make_request(ACT_RELOAD, Q_MAX, Q_MIN));
  endtask

  task automatic test_directed_corners();
    // Quarter-turn steps walk the vector through all four axes
    load_setup(0, Q_ONE, Q_ONE, 0);
    send_request(make_request(ACT_RELOAD, 5, -5));
    send_request(make_request(ACT_TICK, Q_MAX, Q_MIN));
    send_request(make_request(ACT_TICK, Q_MIN, Q_MAX));
    send_request(make_request(ACT_TICK, Q_MAX, Q_MIN));
    send_request(make_request(ACT_TICK, Q_MIN, Q_MAX));
    // Half gains put products on exact rounding ties of either sign
    load_setup(Q_ONE, 0, Q_ONE / 2, -Q_ONE / 2);
    send_request(make_request(ACT_RELOAD, 0, 0));
    send_request(make_request(ACT_TICK, 1, -1));
    send_request(make_request(ACT_TICK, 3, -3));
    // Full-scale matrix and start vector saturate the state and the gains
    load_setup(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_request(make_request(ACT_RELOAD, Q_MAX, Q_MIN));
    send_request(make_request(ACT_TICK, Q_MAX, Q_MIN));
    send_request(make_request(ACT_TICK, Q_MIN, Q_MAX));
    send_request(make_request(ACT_TICK, Q_MAX, Q_MAX));
    load_setup(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    send_request(make_request(ACT_RELOAD, 0, 0));
    send_request(make_request(ACT_TICK, Q_MIN, Q_MIN));
    send_request(make_request(ACT_TICK, Q_MAX, Q_MIN));
    // Zero vector: no gain, no flags
    load_setup(Q_ONE, 0, 0, 0);
    send_request(make_request(ACT_RELOAD, Q_MAX, Q_MIN));
    send_request(make_request(ACT_TICK, Q_MAX, Q_MIN));
    wait_drained();
  endtask

  task automatic test_idle_phases();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 78; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 78; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        program_random_setup();
        // Start each setting from its start vector
        send_request(random_request(100));
        for (int n = 0; n < 119; n++)
          send_request(random_request(4));
      end
      wait_drained();
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // Hold the output long enough for the block to fill and stall its input
  task automatic test_backpressure();
    program_random_setup();
    hold_len <= 60;
    hold_go  <= ~hold_go;
    for (int n = 0; n < 30; n++)
      send_request(random_request(5));
    // Pause the sender until every frame is back
    wait_drained();
    sink_stall_pct = 33;
    for (int n = 0; n < 20; n++)
      send_request(random_request(5));
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_corners();
    test_idle_phases();
    test_backpressure();
    wait_drained();
    if (fault_count == 0 && frames_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
